/* src/wind_angle_circular_filter_core_defines.svh */
// Assertion macros for the filter core source.
`ifndef WIND_ANGLE_CIRCULAR_FILTER_CORE_DEFINES_SVH
`define WIND_ANGLE_CIRCULAR_FILTER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WACF_ASSERT_IMP(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("wacf: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WACF_ASSERT_NXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("wacf: next-cycle check failed");

`endif

/* src/wacf_pkg.sv */
// ----------------------------------------------------------------------------
// wacf_pkg
// Types, codes and constants shared by the wind angle circular filter.
// ----------------------------------------------------------------------------
package wacf_pkg;

	localparam int ANGLE_BITS     = 16;
	localparam int WINDOW_MAX_DEF = 64;
	localparam int OP_W           = 3;
	localparam int TIME_W         = 48;
	localparam int AGE_W          = 32;
	localparam int WEIGHT_BITS    = 16;
	localparam int CFG_DATA_W     = 32;
	localparam int CFG_IDX_W      = 3;

	typedef logic signed [ANGLE_BITS-1:0] angle_t;
	typedef logic [OP_W-1:0]              op_t;
	typedef logic [CFG_IDX_W-1:0]         cfg_idx_t;
	typedef logic [1:0]                   sel_t;

	localparam op_t OP_COURSE     = 3'd0;
	localparam op_t OP_YAW        = 3'd1;
	localparam op_t OP_TRUE_WIND  = 3'd2;
	localparam op_t OP_APPARENT   = 3'd3;
	localparam op_t OP_TACK_START = 3'd4;
	localparam op_t OP_TACK_END   = 3'd5;

	localparam cfg_idx_t REG_MAX_AGE    = 3'd0;
	localparam cfg_idx_t REG_USE_FIXED  = 3'd1;
	localparam cfg_idx_t REG_FIXED_WIND = 3'd2;
	localparam cfg_idx_t REG_ALPHA_WIN  = 3'd3;
	localparam cfg_idx_t REG_ALPHA_TACK = 3'd4;
	localparam cfg_idx_t REG_WIND_WIN   = 3'd5;
	localparam cfg_idx_t REG_WIND_TACK  = 3'd6;
	localparam cfg_idx_t REG_APP_WIN    = 3'd7;

	localparam sel_t SEL_ALPHA = 2'd0;
	localparam sel_t SEL_WIND  = 2'd1;
	localparam sel_t SEL_APP   = 2'd2;

	// Per-cycle commands from the sequencer to one sample window.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic clear;
	} win_cmd_t;

endpackage

/* src/wacf_if.sv */
// ----------------------------------------------------------------------------
// wacf_sample_if / wacf_result_if
// Valid/ready channels for input events and filter results.
// ----------------------------------------------------------------------------
interface wacf_sample_if;
	import wacf_pkg::*;

	logic                valid;
	logic                ready;
	op_t                 operation;
	angle_t              angle;
	angle_t              rate;
	logic [TIME_W-1:0]   timestamp_us;

	modport source(output valid, operation, angle, rate, timestamp_us, input ready);
	modport sink(input valid, operation, angle, rate, timestamp_us, output ready);
endinterface

interface wacf_result_if;
	import wacf_pkg::*;

	logic   valid;
	logic   ready;
	angle_t alpha_mean;
	angle_t alpha_from_yaw;
	angle_t wind_mean;
	angle_t apparent_mean;
	angle_t yaw_rate;
	logic   tacking;

	modport source(output valid, alpha_mean, alpha_from_yaw, wind_mean, apparent_mean,
		yaw_rate, tacking, input ready);
	modport sink(input valid, alpha_mean, alpha_from_yaw, wind_mean, apparent_mean,
		yaw_rate, tacking, output ready);
endinterface

/* src/wacf_ram.sv */
// ----------------------------------------------------------------------------
// wacf_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module wacf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

/* src/wacf_window.sv */
// ----------------------------------------------------------------------------
// wacf_window
// One ring window of angles: RAM plus per-entry valid bits and a fill value.
// ----------------------------------------------------------------------------
module wacf_window #(
	parameter int WINDOW_MAX = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wacf_pkg::win_cmd_t            cmd,
	input  logic [$clog2(WINDOW_MAX)-1:0] wr_addr,
	input  wacf_pkg::angle_t              wr_data,
	input  logic [$clog2(WINDOW_MAX)-1:0] rd_addr,
	input  wacf_pkg::angle_t              fill_value,
	output wacf_pkg::angle_t              rd_data
);
	import wacf_pkg::*;

	logic [WINDOW_MAX-1:0]  valid_q;
	angle_t                 fill_q;
	logic                   valid_s1;
	logic [ANGLE_BITS-1:0]  ram_rd;

	// A clear marks every entry as holding the fill value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			fill_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.clear) begin
				valid_q <= '0;
				fill_q  <= fill_value;
			end else if (cmd.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (cmd.rd_en) begin
				valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	wacf_ram #(
		.WIDTH(ANGLE_BITS),
		.DEPTH(WINDOW_MAX)
	) u_ram (
		.clk    (clk),
		.wr_en  (cmd.wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (cmd.rd_en),
		.rd_addr(rd_addr),
		.rd_data(ram_rd)
	);

	assign rd_data = valid_s1 ? angle_t'(ram_rd) : fill_q;
endmodule

/* src/wacf_div.sv */
// ----------------------------------------------------------------------------
// wacf_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wacf_div #(
	parameter int Q_W = 25,
	parameter int D_W = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [D_W-1:0]           rem_init,
	input  logic [Q_W-1:0]           dividend,
	input  logic [D_W-1:0]           divisor,
	input  logic [$clog2(Q_W+1)-1:0] steps,
	output logic [Q_W-1:0]           quotient,
	output logic                     done
);
	localparam int CNT_W = $clog2(Q_W+1);

	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   div_q;
	logic [Q_W-1:0]   dv_q;
	logic [Q_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [D_W:0]     r2;
	logic [D_W:0]     r_sub;
	logic             ge;

	// The remainder shifts in the next dividend bit; it stays below the divisor.
	assign r2    = {rem_q, dv_q[Q_W-1]};
	assign ge    = r2 >= {1'b0, div_q};
	assign r_sub = r2 - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			dv_q  <= dividend;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? r_sub[D_W-1:0] : r2[D_W-1:0];
			dv_q  <= dv_q << 1;
			quo_q <= {quo_q[Q_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;
endmodule

/* src/wind_angle_circular_filter_core.sv */
// ----------------------------------------------------------------------------
// wind_angle_circular_filter_core
// Angle-to-wind filter with three Mitsuta circular-mean ring windows.
// ----------------------------------------------------------------------------
// The core takes one timestamped event at a time (course, yaw with rate, true
// wind, apparent wind, tack start, tack end) and returns one result per event,
// holding the filter state after that event. Each event is worked through by a
// small sequencer that drives one shared restoring divider and walks the
// selected window one RAM read per cycle, so the input is not ready while an
// event is in work. With L the effective window length and SUM_W the width of
// the window sum (25 bits at the default 64-entry windows), a wind or
// apparent-wind sample is written, its L entries are read and their sum is
// divided in SUM_W steps; a course or yaw sample first runs the blend weight
// division (skipped once the course age reaches its limit); tack events, a
// repeated course or an unused code go straight out. A finished result sits
// in an output register, and the next event is accepted while it waits to be
// taken. Windows need no clearing pass: each entry has a valid bit, and an
// entry that is not valid reads as the window's fill value (zero after reset
// or a length change, the window mean after a tack transfer).
// ----------------------------------------------------------------------------
`include "wind_angle_circular_filter_core_defines.svh"

module wind_angle_circular_filter_core #(
	parameter int WINDOW_MAX = wacf_pkg::WINDOW_MAX_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	wacf_sample_if.sink                           sample,
	wacf_result_if.source                         result,
	input  logic                                  cfg_we,
	input  wacf_pkg::cfg_idx_t                    cfg_index,
	input  logic [wacf_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import wacf_pkg::*;

	localparam int PTR_W = $clog2(WINDOW_MAX);
	localparam int LEN_W = $clog2(WINDOW_MAX + 1);
	// Unwrapped samples lie in [-TURN, 2*TURN).
	localparam int D_W   = ANGLE_BITS + 2;
	localparam int SUM_W = D_W + LEN_W;
	localparam int CNT_W = $clog2(SUM_W + 1);
	localparam int HALF  = 1 << (ANGLE_BITS - 1);
	localparam int TURN  = 1 << ANGLE_BITS;

	localparam logic signed [D_W:0]   HALF_X     = (D_W+1)'(HALF);
	localparam logic signed [D_W:0]   NEG_HALF_X = (D_W+1)'(-HALF);
	localparam logic signed [D_W-1:0] TURN_D     = D_W'(TURN);

	localparam int ST_W = 4;
	localparam logic [ST_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [ST_W-1:0] ST_DECODE = 4'd1;
	localparam logic [ST_W-1:0] ST_AGE    = 4'd2;
	localparam logic [ST_W-1:0] ST_WDIV   = 4'd3;
	localparam logic [ST_W-1:0] ST_MUL    = 4'd4;
	localparam logic [ST_W-1:0] ST_BLEND  = 4'd5;
	localparam logic [ST_W-1:0] ST_PUSH   = 4'd6;
	localparam logic [ST_W-1:0] ST_RD     = 4'd7;
	localparam logic [ST_W-1:0] ST_MDIV   = 4'd8;
	localparam logic [ST_W-1:0] ST_OUT    = 4'd9;

	// Configuration registers.
	logic [AGE_W-1:0] max_age_q;
	logic             use_fixed_q;
	angle_t           fixed_wind_q;
	logic [LEN_W-1:0] alpha_win_q, alpha_tack_q, wind_win_q, wind_tack_q, app_win_q;

	// Filter state.
	logic [ST_W-1:0]   state_q;
	logic [PTR_W-1:0]  alpha_ptr_q, wind_ptr_q, app_ptr_q;
	angle_t            alpha_filt_q, wind_filt_q, app_filt_q;
	angle_t            alpha_course_q, alpha_yaw_q, last_course_q, yaw_rate_q;
	logic [TIME_W-1:0] lct_q;
	logic              tack_q;
	sel_t              sel_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              rd_vld_s1;

	// Datapath registers.
	op_t                     op_q;
	angle_t                  angle_in_q, rate_in_q;
	logic [TIME_W-1:0]       now_q;
	logic [WEIGHT_BITS:0]    w_q;
	logic signed [34:0]      prod_q;
	angle_t                  push_val_q;
	logic                    rd_first_s1;
	logic signed [D_W-1:0]   d_q;
	logic signed [SUM_W-1:0] sum_q;
	logic                    sum_neg_q;

	// Output register.
	logic   out_valid_q;
	angle_t res_alpha_q, res_yaw_alpha_q, res_wind_q, res_app_q, res_rate_q;
	logic   res_tack_q;

	// Combinational signals.
	angle_t            wind_ref, inst_alpha, blend_q16, rd_data, mean_val, mq;
	angle_t            alpha_rd, wind_rd, app_rd;
	logic [LEN_W-1:0]  alpha_len, wind_len, sel_len, cfg_len;
	logic [PTR_W-1:0]  sel_ptr, ptr_next;
	logic [LEN_W:0]    ptr_inc;
	logic [TIME_W-1:0] age;
	logic              age_full, cfg_nz, tack_flip, out_load, accept;
	logic              alpha_cfg_clr, wind_cfg_clr, app_cfg_clr;
	win_cmd_t          alpha_cmd, wind_cmd, app_cmd;
	angle_t            alpha_fill;
	logic signed [D_W-1:0]   t_val, d_new;
	logic signed [D_W:0]     delta;
	logic signed [SUM_W-1:0] sum_next;
	logic [SUM_W-1:0]        sum_abs;
	logic signed [16:0]      yaw_diff;
	logic signed [34:0]      blend_sum;
	logic                    div_start, div_done;
	logic [AGE_W-1:0]        div_rem_init, div_divisor;
	logic [SUM_W-1:0]        div_dividend, div_quot;
	logic [CNT_W-1:0]        div_steps;

	assign accept       = sample.valid && sample.ready;
	assign sample.ready = (state_q == ST_IDLE);

	// Alpha relative to the true wind in use, wrapped to the angle range.
	assign wind_ref   = use_fixed_q ? fixed_wind_q : wind_filt_q;
	assign inst_alpha = angle_t'(angle_in_q - wind_ref);

	// Tack lengths only apply while tacking, and never exceed the normal length.
	assign alpha_len = (tack_q && (alpha_tack_q < alpha_win_q)) ? alpha_tack_q : alpha_win_q;
	assign wind_len  = (tack_q && (wind_tack_q < wind_win_q)) ? wind_tack_q : wind_win_q;

	always_comb begin
		case (sel_q)
			SEL_ALPHA: begin
				sel_len = alpha_len;
				sel_ptr = alpha_ptr_q;
				rd_data = alpha_rd;
			end
			SEL_WIND: begin
				sel_len = wind_len;
				sel_ptr = wind_ptr_q;
				rd_data = wind_rd;
			end
			default: begin
				sel_len = app_win_q;
				sel_ptr = app_ptr_q;
				rd_data = app_rd;
			end
		endcase
	end

	assign ptr_inc  = (LEN_W+1)'(sel_ptr) + (LEN_W+1)'(1);
	assign ptr_next = (ptr_inc >= (LEN_W+1)'(sel_len)) ? '0 : ptr_inc[PTR_W-1:0];

	// Course age; the weight saturates at one once the age reaches the limit.
	assign age      = now_q - lct_q;
	assign age_full = age >= TIME_W'(max_age_q);

	// Length writes: zero is ignored, large values saturate.
	assign cfg_nz  = (cfg_data != '0);
	assign cfg_len = (cfg_data > CFG_DATA_W'(WINDOW_MAX)) ? LEN_W'(WINDOW_MAX) :
		cfg_data[LEN_W-1:0];
	assign alpha_cfg_clr = cfg_we && (cfg_index == REG_ALPHA_WIN) && cfg_nz &&
		(cfg_len != alpha_win_q);
	assign wind_cfg_clr  = cfg_we && (cfg_index == REG_WIND_WIN) && cfg_nz &&
		(cfg_len != wind_win_q);
	assign app_cfg_clr   = cfg_we && (cfg_index == REG_APP_WIN) && cfg_nz &&
		(cfg_len != app_win_q);

	assign tack_flip = (state_q == ST_DECODE) &&
		(((op_q == OP_TACK_START) && !tack_q) || ((op_q == OP_TACK_END) && tack_q));

	// A tack transfer refills the alpha and wind windows with their means.
	assign alpha_fill = tack_flip ? alpha_filt_q : '0;

	always_comb begin
		alpha_cmd.clear = alpha_cfg_clr || tack_flip;
		alpha_cmd.wr_en = (state_q == ST_PUSH) && (sel_q == SEL_ALPHA);
		alpha_cmd.rd_en = (state_q == ST_RD) && (cnt_q < sel_len) && (sel_q == SEL_ALPHA);
		wind_cmd.clear  = wind_cfg_clr || tack_flip;
		wind_cmd.wr_en  = (state_q == ST_PUSH) && (sel_q == SEL_WIND);
		wind_cmd.rd_en  = (state_q == ST_RD) && (cnt_q < sel_len) && (sel_q == SEL_WIND);
		app_cmd.clear   = app_cfg_clr;
		app_cmd.wr_en   = (state_q == ST_PUSH) && (sel_q == SEL_APP);
		app_cmd.rd_en   = (state_q == ST_RD) && (cnt_q < sel_len) && (sel_q == SEL_APP);
	end

	wacf_window #(.WINDOW_MAX(WINDOW_MAX)) u_alpha_win (
		.clk(clk), .arst_n(arst_n), .cmd(alpha_cmd), .wr_addr(sel_ptr),
		.wr_data(push_val_q), .rd_addr(cnt_q[PTR_W-1:0]), .fill_value(alpha_fill),
		.rd_data(alpha_rd)
	);

	wacf_window #(.WINDOW_MAX(WINDOW_MAX)) u_wind_win (
		.clk(clk), .arst_n(arst_n), .cmd(wind_cmd), .wr_addr(sel_ptr),
		.wr_data(push_val_q), .rd_addr(cnt_q[PTR_W-1:0]),
		.fill_value(tack_flip ? wind_filt_q : angle_t'(0)), .rd_data(wind_rd)
	);

	wacf_window #(.WINDOW_MAX(WINDOW_MAX)) u_app_win (
		.clk(clk), .arst_n(arst_n), .cmd(app_cmd), .wr_addr(sel_ptr),
		.wr_data(push_val_q), .rd_addr(cnt_q[PTR_W-1:0]), .fill_value(angle_t'(0)),
		.rd_data(app_rd)
	);

	// Mitsuta unwrap: each sample, taken in [0, TURN), moves by at most half a
	// turn from the previous unwrapped value.
	assign t_val = D_W'({2'b00, rd_data});
	assign delta = (D_W+1)'(t_val) - (D_W+1)'(d_q);

	always_comb begin
		if (rd_first_s1) begin
			d_new = t_val;
		end else if (delta < NEG_HALF_X) begin
			d_new = t_val + TURN_D;
		end else if (delta < HALF_X) begin
			d_new = t_val;
		end else begin
			d_new = t_val - TURN_D;
		end
	end

	assign sum_next = rd_first_s1 ? SUM_W'(d_new) : (sum_q + SUM_W'(d_new));
	assign sum_abs  = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);

	// The divider serves the blend weight and the window mean.
	always_comb begin
		if (state_q == ST_AGE) begin
			div_start    = !age_full;
			div_rem_init = age[AGE_W-1:0];
			div_dividend = '0;
			div_divisor  = max_age_q;
			div_steps    = CNT_W'(WEIGHT_BITS);
		end else begin
			div_start    = (state_q == ST_RD) && (cnt_q >= sel_len) && !rd_vld_s1;
			div_rem_init = '0;
			div_dividend = sum_abs;
			div_divisor  = AGE_W'(sel_len);
			div_steps    = CNT_W'(SUM_W);
		end
	end

	wacf_div #(.Q_W(SUM_W), .D_W(AGE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .rem_init(div_rem_init),
		.dividend(div_dividend), .divisor(div_divisor), .steps(div_steps),
		.quotient(div_quot), .done(div_done)
	);

	// Division truncates toward zero, so the sign is put back after it.
	assign mq       = angle_t'(div_quot[ANGLE_BITS-1:0]);
	assign mean_val = sum_neg_q ? angle_t'(-mq) : mq;

	// Blend = course + round(w * (yaw - course) / 2^16), ties upward.
	assign yaw_diff  = 17'(alpha_yaw_q) - 17'(alpha_course_q);
	assign blend_sum = prod_q + 35'sd32768;
	assign blend_q16 = angle_t'(alpha_course_q + angle_t'(blend_sum[31:16]));

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_age_q      <= AGE_W'(2000000);
			use_fixed_q    <= 1'b0;
			fixed_wind_q   <= '0;
			alpha_win_q    <= LEN_W'(1);
			alpha_tack_q   <= LEN_W'(1);
			wind_win_q     <= LEN_W'(1);
			wind_tack_q    <= LEN_W'(1);
			app_win_q      <= LEN_W'(1);
			state_q        <= ST_IDLE;
			alpha_ptr_q    <= '0;
			wind_ptr_q     <= '0;
			app_ptr_q      <= '0;
			alpha_filt_q   <= '0;
			wind_filt_q    <= '0;
			app_filt_q     <= '0;
			alpha_course_q <= '0;
			alpha_yaw_q    <= '0;
			last_course_q  <= '0;
			yaw_rate_q     <= '0;
			lct_q          <= '0;
			tack_q         <= 1'b0;
			sel_q          <= SEL_ALPHA;
			cnt_q          <= '0;
			rd_vld_s1      <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			// Registers are to be written only while the core is idle; the core does not enforce it.
			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_AGE:    max_age_q    <= cfg_data[AGE_W-1:0];
					REG_USE_FIXED:  use_fixed_q  <= cfg_data[0];
					REG_FIXED_WIND: fixed_wind_q <= angle_t'(cfg_data[ANGLE_BITS-1:0]);
					REG_ALPHA_TACK: if (cfg_nz) alpha_tack_q <= cfg_len;
					REG_WIND_TACK:  if (cfg_nz) wind_tack_q  <= cfg_len;
					default: ;
				endcase
			end
			if (alpha_cfg_clr) begin
				alpha_win_q  <= cfg_len;
				alpha_ptr_q  <= '0;
				alpha_filt_q <= '0;
			end
			if (wind_cfg_clr) begin
				wind_win_q  <= cfg_len;
				wind_ptr_q  <= '0;
				wind_filt_q <= '0;
			end
			if (app_cfg_clr) begin
				app_win_q  <= cfg_len;
				app_ptr_q  <= '0;
				app_filt_q <= '0;
			end

			rd_vld_s1 <= (state_q == ST_RD) && (cnt_q < sel_len);

			if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					state_q <= ST_OUT;
					case (op_q)
						OP_COURSE: begin
							// A repeated course leaves the filter state unchanged.
							if (angle_in_q != last_course_q) begin
								last_course_q  <= angle_in_q;
								lct_q          <= now_q;
								alpha_course_q <= inst_alpha;
								state_q        <= ST_AGE;
							end
						end
						OP_YAW: begin
							alpha_yaw_q <= inst_alpha;
							yaw_rate_q  <= rate_in_q;
							state_q     <= ST_AGE;
						end
						OP_TRUE_WIND: begin
							sel_q   <= SEL_WIND;
							state_q <= ST_PUSH;
						end
						OP_APPARENT: begin
							sel_q   <= SEL_APP;
							state_q <= ST_PUSH;
						end
						OP_TACK_START, OP_TACK_END: begin
							if (tack_flip) begin
								tack_q      <= !tack_q;
								alpha_ptr_q <= '0;
								wind_ptr_q  <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_AGE: begin
					sel_q   <= SEL_ALPHA;
					state_q <= age_full ? ST_MUL : ST_WDIV;
				end
				ST_WDIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_BLEND;
				end
				ST_BLEND: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					case (sel_q)
						SEL_ALPHA: alpha_ptr_q <= ptr_next;
						SEL_WIND:  wind_ptr_q  <= ptr_next;
						default:   app_ptr_q   <= ptr_next;
					endcase
					cnt_q   <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (cnt_q < sel_len) begin
						cnt_q <= cnt_q + LEN_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_MDIV;
					end
				end
				ST_MDIV: begin
					if (div_done) begin
						case (sel_q)
							SEL_ALPHA: alpha_filt_q <= mean_val;
							SEL_WIND:  wind_filt_q  <= mean_val;
							default:   app_filt_q   <= mean_val;
						endcase
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= sample.operation;
			angle_in_q <= sample.angle;
			rate_in_q  <= sample.rate;
			now_q      <= sample.timestamp_us;
		end
		if (state_q == ST_AGE) begin
			w_q <= (WEIGHT_BITS+1)'(1) << WEIGHT_BITS;
		end else if ((state_q == ST_WDIV) && div_done) begin
			w_q <= {1'b0, div_quot[WEIGHT_BITS-1:0]};
		end
		if (state_q == ST_MUL) begin
			prod_q <= $signed({1'b0, w_q}) * yaw_diff;
		end
		if (state_q == ST_BLEND) begin
			push_val_q <= blend_q16;
		end else if (state_q == ST_DECODE) begin
			push_val_q <= angle_in_q;
		end
		rd_first_s1 <= (cnt_q == '0);
		if (rd_vld_s1) begin
			d_q   <= d_new;
			sum_q <= sum_next;
		end
		if (div_start && (state_q == ST_RD)) begin
			sum_neg_q <= sum_q[SUM_W-1];
		end
		if (out_load) begin
			res_alpha_q     <= angle_t'(-alpha_filt_q);
			res_yaw_alpha_q <= angle_t'(-alpha_yaw_q);
			res_wind_q      <= wind_filt_q;
			res_app_q       <= app_filt_q;
			res_rate_q      <= yaw_rate_q;
			res_tack_q      <= tack_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.alpha_mean     = res_alpha_q;
	assign result.alpha_from_yaw = res_yaw_alpha_q;
	assign result.wind_mean      = res_wind_q;
	assign result.apparent_mean  = res_app_q;
	assign result.yaw_rate       = res_rate_q;
	assign result.tacking        = res_tack_q;

	`WACF_ASSERT_NXT(a_accept_leaves_idle, accept, state_q == ST_DECODE)
	`WACF_ASSERT_IMP(a_div_done_waited, div_done, (state_q == ST_WDIV) || (state_q == ST_MDIV))
	`WACF_ASSERT_NXT(a_result_loaded, out_load, result.valid && (state_q == ST_IDLE))
endmodule
